// File: rtl/cti_pkg.sv
// ----------------------------------------------------------------------------
// cti_pkg
// Shared widths, codes and types of the timed cue interval lookup block.
// ----------------------------------------------------------------------------
package cti_pkg;

    localparam int TIME_W          = 31;
    localparam int LINE_W          = 16;
    localparam int SLOT_W          = 8;
    localparam int COUNT_W         = 9;
    localparam int Q_W             = 16;
    localparam int ENTRY_W         = TIME_W + LINE_W;
    localparam int MAX_ENTRIES_DEF = 256;

    // APB register map: two registers on the 32-bit data bus at byte addresses 0 and 4.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    localparam logic REG_ENTRY_COUNT = 1'b0;
    localparam logic REG_SONG_END    = 1'b1;

    typedef struct packed {
        logic              start;
        logic [TIME_W-1:0] dividend;
        logic [TIME_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic           done;
        logic [Q_W-1:0] quotient;
    } div_rsp_t;

endpackage

// File: rtl/cti_req_if.sv
// ----------------------------------------------------------------------------
// cti_req_if
// Request channel: table writes and time queries, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cti_req_if;

    logic                        valid;
    logic                        ready;
    logic                        command;
    logic [cti_pkg::SLOT_W-1:0]  entry_index;
    logic [cti_pkg::TIME_W-1:0]  cue_start;
    logic [cti_pkg::LINE_W-1:0]  line_id;
    logic [cti_pkg::TIME_W-1:0]  query_time;

    modport source
    (
        output valid, command, entry_index, cue_start, line_id, query_time,
        input  ready
    );

    modport sink
    (
        input  valid, command, entry_index, cue_start, line_id, query_time,
        output ready
    );

endinterface

// File: rtl/cti_rsp_if.sv
// ----------------------------------------------------------------------------
// cti_rsp_if
// Result channel: one lookup result per query, valid/ready handshake.
// ----------------------------------------------------------------------------
interface cti_rsp_if;

    logic                        valid;
    logic                        ready;
    logic                        found;
    logic [cti_pkg::SLOT_W-1:0]  hit_index;
    logic [cti_pkg::LINE_W-1:0]  hit_line_id;
    logic [cti_pkg::Q_W-1:0]     progress;

    modport source
    (
        output valid, found, hit_index, hit_line_id, progress,
        input  ready
    );

    modport sink
    (
        input  valid, found, hit_index, hit_line_id, progress,
        output ready
    );

endinterface

// File: rtl/cti_ram.sv
// ----------------------------------------------------------------------------
// cti_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module cti_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/cti_div.sv
// ----------------------------------------------------------------------------
// cti_div
// Restoring divider for the Q0.16 progress fraction, one quotient bit a cycle.
// ----------------------------------------------------------------------------
module cti_div (
    input  logic              clk,
    input  logic              rst_n,
    input  cti_pkg::div_req_t req,
    output cti_pkg::div_rsp_t rsp
);

    localparam int STEPS = cti_pkg::Q_W;
    localparam int CNT_W = $clog2(STEPS);
    localparam int TW    = cti_pkg::TIME_W;

    logic                 busy_reg;
    logic                 busy_next;
    logic                 done_reg;
    logic                 done_next;
    logic [CNT_W-1:0]     cnt_reg;
    logic [CNT_W-1:0]     cnt_next;
    logic [TW-1:0]        rem_reg;
    logic [TW-1:0]        rem_next;
    logic [TW-1:0]        den_reg;
    logic [TW-1:0]        den_next;
    logic [STEPS-1:0]     quo_reg;
    logic [STEPS-1:0]     quo_next;

    logic [TW:0]          shifted;
    logic [TW:0]          diff;
    logic                 fits;
    logic                 last_step;

    // The remainder always stays below the divisor, so one doubling fits in
    // one extra bit.
    assign shifted   = {rem_reg, 1'b0};
    assign diff      = shifted - {1'b0, den_reg};
    assign fits      = shifted >= {1'b0, den_reg};
    assign last_step = cnt_reg == CNT_W'(STEPS - 1);

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = req.dividend;
            den_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TW-1:0] : shifted[TW-1:0];
            quo_next = {quo_reg[STEPS-2:0], fits};
            cnt_next = cnt_reg + CNT_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> ##(STEPS + 1) done_reg)
        else $error("divider result did not appear after the fixed step count");

endmodule

// File: rtl/timed_cue_interval_lookup.sv
// ----------------------------------------------------------------------------
// timed_cue_interval_lookup
// Cue table lookup: finds the cue whose interval holds a query time and
// returns its slot, line id and Q0.16 progress through the interval.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake                 Carries
//  -------   ---------  ------------------------  --------------------------------
//  req       in         valid/ready               table write or time query
//  rsp       out        valid/ready               found, slot, line id, progress
//  apb       in         psel/penable/pready       entry_count, song_end_time
//
//  A table write goes into the cue RAM as it is accepted. A query reads one cue
//  entry a cycle until it decides; on a hit the divider then computes the
//  progress, and the result is loaded into the output register.
//  Reset clears the control state and the configuration registers; the cue RAM is not cleared.
//  A result waits in the output register while rsp is stalled, and the next
//  transaction is taken once the previous result has been loaded there.
//
module timed_cue_interval_lookup #(
    parameter int MAX_ENTRIES = cti_pkg::MAX_ENTRIES_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    cti_req_if.sink                            req,
    cti_rsp_if.source                          rsp,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cti_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [cti_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [cti_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int IDX_W = $clog2(MAX_ENTRIES);
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam int TW    = cti_pkg::TIME_W;
    localparam int LW    = cti_pkg::LINE_W;
    localparam int SW    = cti_pkg::SLOT_W;
    localparam int QW    = cti_pkg::Q_W;
    localparam int EW    = cti_pkg::ENTRY_W;

    typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DIV, ST_OUT} state_t;

    // Configuration registers
    logic [cti_pkg::COUNT_W-1:0] entry_count_reg;
    logic [TW-1:0]               song_end_reg;
    logic                        cfg_write;

    // Control state
    state_t                      state_reg;
    state_t                      state_next;
    logic [CNT_W-1:0]            rd_idx_reg;
    logic [CNT_W-1:0]            rd_idx_next;
    logic                        rsp_vld_reg;
    logic                        rsp_vld_next;
    logic                        out_valid_reg;
    logic                        out_valid_next;

    // Payload
    logic [TW-1:0]               t_reg;
    logic [TW-1:0]               t_next;
    logic [CNT_W-1:0]            n_reg;
    logic [CNT_W-1:0]            n_next;
    logic [CNT_W-1:0]            rsp_idx_reg;
    logic [CNT_W-1:0]            rsp_idx_next;
    logic [TW-1:0]               prev_start_reg;
    logic [TW-1:0]               prev_start_next;
    logic [LW-1:0]               prev_line_reg;
    logic [LW-1:0]               prev_line_next;
    logic                        found_reg;
    logic                        found_next;
    logic [SW-1:0]               hit_idx_reg;
    logic [SW-1:0]               hit_idx_next;
    logic [LW-1:0]               hit_line_reg;
    logic [LW-1:0]               hit_line_next;
    logic [QW-1:0]               progress_reg;
    logic [QW-1:0]               progress_next;
    logic                        out_found_reg;
    logic                        out_found_next;
    logic [SW-1:0]               out_index_reg;
    logic [SW-1:0]               out_index_next;
    logic [LW-1:0]               out_line_reg;
    logic [LW-1:0]               out_line_next;
    logic [QW-1:0]               out_progress_reg;
    logic [QW-1:0]               out_progress_next;

    // RAM and divider connections
    logic                        ram_we;
    logic [IDX_W-1:0]            ram_waddr;
    logic                        ram_re;
    logic [EW-1:0]               ram_rdata;
    cti_pkg::div_req_t           div_req;
    cti_pkg::div_rsp_t           div_rsp;

    // Helpers
    logic                        req_fire;
    logic [31:0]                 slot_wide;
    logic                        slot_ok;
    logic [CNT_W-1:0]            n_capped;
    logic                        issue;
    logic [TW-1:0]               d_start;
    logic [LW-1:0]               d_line;
    logic                        is_first;
    logic                        is_last;
    logic                        first_miss;
    logic                        prev_hit;
    logic                        last_hit;
    logic [31:0]                 rsp_idx_wide;
    logic [31:0]                 prev_idx_wide;
    logic                        out_load;

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_count_reg <= '0;
            song_end_reg    <= '0;
        end
        else if (cfg_write)
        begin
            case (paddr[2])
                cti_pkg::REG_ENTRY_COUNT: entry_count_reg <= pwdata[cti_pkg::COUNT_W-1:0];
                cti_pkg::REG_SONG_END:    song_end_reg    <= pwdata[TW-1:0];
                default:                  entry_count_reg <= entry_count_reg;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[2])
            cti_pkg::REG_ENTRY_COUNT: prdata = 32'(entry_count_reg);
            cti_pkg::REG_SONG_END:    prdata = 32'(song_end_reg);
            default:                  prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Cue RAM: start time in the upper bits, line id in the lower bits.
    // Writes are taken only while idle, so they never overlap a scan.
    // ------------------------------------------------------------------
    assign req.ready = state_reg == ST_IDLE;
    assign req_fire  = req.valid && req.ready;
    assign slot_wide = 32'(req.entry_index);
    assign slot_ok   = slot_wide < 32'(MAX_ENTRIES);
    assign ram_we    = req_fire && (req.command == cti_pkg::CMD_WRITE) && slot_ok;
    assign ram_waddr = slot_wide[IDX_W-1:0];

    assign n_capped  = (32'(entry_count_reg) > 32'(MAX_ENTRIES)) ?
                       CNT_W'(MAX_ENTRIES) : CNT_W'(entry_count_reg);

    assign issue     = (state_reg == ST_SCAN) && (rd_idx_reg < n_reg);
    assign ram_re    = issue;

    cti_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata ({req.cue_start, req.line_id}),
        .re    (ram_re),
        .raddr (rd_idx_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Scan compare: each returned entry closes the previous entry's
    // interval; the last entry is closed by the song end time.
    // ------------------------------------------------------------------
    assign d_start       = ram_rdata[EW-1:LW];
    assign d_line        = ram_rdata[LW-1:0];
    assign is_first      = rsp_idx_reg == '0;
    assign is_last       = rsp_idx_reg == (n_reg - CNT_W'(1));
    assign first_miss    = is_first && (t_reg < d_start);
    assign prev_hit      = !is_first && (t_reg >= prev_start_reg) && (t_reg < d_start);
    assign last_hit      = is_last && (t_reg >= d_start) && (t_reg < song_end_reg);
    assign rsp_idx_wide  = 32'(rsp_idx_reg);
    assign prev_idx_wide = 32'(rsp_idx_reg - CNT_W'(1));

    cti_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign out_load = !out_valid_reg || rsp.ready;

    always_comb
    begin
        state_next        = state_reg;
        rd_idx_next       = rd_idx_reg;
        rsp_vld_next      = issue;
        rsp_idx_next      = rd_idx_reg;
        out_valid_next    = out_valid_reg && !rsp.ready;
        t_next            = t_reg;
        n_next            = n_reg;
        prev_start_next   = prev_start_reg;
        prev_line_next    = prev_line_reg;
        found_next        = found_reg;
        hit_idx_next      = hit_idx_reg;
        hit_line_next     = hit_line_reg;
        progress_next     = progress_reg;
        out_found_next    = out_found_reg;
        out_index_next    = out_index_reg;
        out_line_next     = out_line_reg;
        out_progress_next = out_progress_reg;
        div_req.start     = 1'b0;
        div_req.dividend  = t_reg - prev_start_reg;
        div_req.divisor   = d_start - prev_start_reg;

        if (issue)
        begin
            rd_idx_next = rd_idx_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_fire && (req.command == cti_pkg::CMD_QUERY))
                begin
                    t_next      = req.query_time;
                    n_next      = n_capped;
                    rd_idx_next = '0;
                    found_next  = 1'b0;
                    if (n_capped == '0)
                    begin
                        state_next = ST_OUT;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                if (rsp_vld_reg)
                begin
                    prev_start_next = d_start;
                    prev_line_next  = d_line;
                    if (first_miss)
                    begin
                        state_next = ST_OUT;
                    end
                    else if (prev_hit)
                    begin
                        div_req.start = 1'b1;
                        hit_idx_next  = prev_idx_wide[SW-1:0];
                        hit_line_next = prev_line_reg;
                        state_next    = ST_DIV;
                    end
                    else if (is_last)
                    begin
                        if (last_hit)
                        begin
                            div_req.start    = 1'b1;
                            div_req.dividend = t_reg - d_start;
                            div_req.divisor  = song_end_reg - d_start;
                            hit_idx_next     = rsp_idx_wide[SW-1:0];
                            hit_line_next    = d_line;
                            state_next       = ST_DIV;
                        end
                        else
                        begin
                            state_next = ST_OUT;
                        end
                    end
                end
            end

            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    progress_next = div_rsp.quotient;
                    found_next    = 1'b1;
                    state_next    = ST_OUT;
                end
            end

            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next    = 1'b1;
                    out_found_next    = found_reg;
                    out_index_next    = found_reg ? hit_idx_reg : '0;
                    out_line_next     = found_reg ? hit_line_reg : '0;
                    out_progress_next = found_reg ? progress_reg : '0;
                    state_next        = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_idx_reg    <= '0;
            rsp_vld_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_idx_reg    <= rd_idx_next;
            rsp_vld_reg   <= rsp_vld_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg            <= t_next;
        n_reg            <= n_next;
        rsp_idx_reg      <= rsp_idx_next;
        prev_start_reg   <= prev_start_next;
        prev_line_reg    <= prev_line_next;
        found_reg        <= found_next;
        hit_idx_reg      <= hit_idx_next;
        hit_line_reg     <= hit_line_next;
        progress_reg     <= progress_next;
        out_found_reg    <= out_found_next;
        out_index_reg    <= out_index_next;
        out_line_reg     <= out_line_next;
        out_progress_reg <= out_progress_next;
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.found       = out_found_reg;
    assign rsp.hit_index   = out_index_reg;
    assign rsp.hit_line_id = out_line_reg;
    assign rsp.progress    = out_progress_reg;

    a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.found) |->
            (rsp.hit_index == '0) && (rsp.hit_line_id == '0) && (rsp.progress == '0))
        else $error("not-found result carries nonzero fields");

    a_div_from_scan: assert property (@(posedge clk) disable iff (!rst_n)
        div_req.start |-> (state_reg == ST_SCAN) && rsp_vld_reg)
        else $error("divider started outside a scan hit");

    a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> (state_reg == ST_DIV))
        else $error("divider finished while no division was pending");

endmodule

// File: tb/sv/tb_timed_cue_interval_lookup.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_timed_cue_interval_lookup
// Self-checking testbench for the timed cue interval lookup block. A short
// directed table covers the empty table, both ends of the time range, empty
// intervals, an out-of-order table and the song end. It is followed by random
// phases that load cue tables of several sizes and shapes, program the
// registers and send mixed writes and queries. Every lookup result is checked
// field by field against hand-written values or an in-order model of the cue table.
// ----------------------------------------------------------------------------
module tb_timed_cue_interval_lookup;

    localparam int TIME_W     = cti_pkg::TIME_W;
    localparam int LINE_W     = cti_pkg::LINE_W;
    localparam int SLOT_W     = cti_pkg::SLOT_W;
    localparam int COUNT_W    = cti_pkg::COUNT_W;
    localparam int Q_W        = cti_pkg::Q_W;
    localparam int APB_ADDR_W = cti_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = cti_pkg::APB_DATA_W;

    localparam int CUE_SLOTS    = cti_pkg::MAX_ENTRIES_DEF;
    localparam int RAND_PHASES  = 14;
    localparam int PHASE_CMDS   = 90;
    localparam int DRAIN_CYCLES = 300;
    localparam int HOLD_CYCLES  = 2000;

    typedef struct packed {
        bit              found;
        bit [SLOT_W-1:0] hit_index;
        bit [LINE_W-1:0] hit_line_id;
        bit [Q_W-1:0]    progress;
    } lookup_t;

    typedef struct {
        bit              command;
        bit [SLOT_W-1:0] slot;
        bit [TIME_W-1:0] start_ms;
        bit [LINE_W-1:0] line;
        bit [TIME_W-1:0] query_ms;
        bit              typed;
        lookup_t         want;
    } cue_cmd_t;

    typedef enum { ROW_ITEM, ROW_REG } row_kind_t;

    typedef struct {
        row_kind_t kind;
        logic      reg_sel;
        bit [31:0] reg_value;
        cue_cmd_t  cmd;
    } dir_row_t;

    typedef enum { LAYOUT_ASCENDING, LAYOUT_SHUFFLED, LAYOUT_HIGH } layout_t;
    typedef enum { RX_OPEN, RX_SPARSE, RX_RUNS } rx_mode_t;

    localparam lookup_t NO_CUE = '0;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    cti_req_if req_ch ();
    cti_rsp_if rsp_ch ();

    timed_cue_interval_lookup dut
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #4 clk = ~clk;

    // Cue table and registers as the block holds them, updated on acceptance.
    bit [TIME_W-1:0]  start_ms_tbl [CUE_SLOTS];
    bit [LINE_W-1:0]  line_tbl [CUE_SLOTS];
    bit [COUNT_W-1:0] live_count;
    bit [TIME_W-1:0]  live_song_end;

    // Table as the stimulus generator intends it, updated when a write is queued.
    bit [TIME_W-1:0]  plan_start [CUE_SLOTS];
    bit [TIME_W-1:0]  plan_song_end;

    lookup_t   lookups_due [$];
    cue_cmd_t  pending_cmds [$];
    dir_row_t  directed_rows [$];

    int        err_count   = 0;
    int        hold_asked  = 0;
    bit        tx_gaps     = 1'b1;
    rx_mode_t  rx_mode     = RX_RUNS;

    function automatic lookup_t lookup_cue(bit [TIME_W-1:0] t);
        lookup_t          r;
        int               n;
        bit [TIME_W-1:0]  s;
        bit [TIME_W-1:0]  e;
        bit [TIME_W+Q_W-1:0] num;
        bit [TIME_W+Q_W-1:0] q;
        r = NO_CUE;
        n = (live_count > CUE_SLOTS) ? CUE_SLOTS : int'(live_count);
        if (n == 0 || t < start_ms_tbl[0])
            return r;
        for (int i = 0; i < n; i++)
        begin
            s = start_ms_tbl[i];
            e = (i + 1 < n) ? start_ms_tbl[i + 1] : live_song_end;
            if (t >= s && t < e)
            begin
                num = {t - s, 16'h0000};
                q   = num / (e - s);
                r.found       = 1'b1;
                r.hit_index   = 8'(i);
                r.hit_line_id = line_tbl[i];
                r.progress    = q[Q_W-1:0];
                return r;
            end
        end
        return r;
    endfunction

    function automatic void commit_cmd(cue_cmd_t c);
        if (c.command == cti_pkg::CMD_WRITE)
        begin
            start_ms_tbl[c.slot] = c.start_ms;
            line_tbl[c.slot]     = c.line;
        end
        else
            lookups_due.push_back(c.typed ? c.want : lookup_cue(c.query_ms));
    endfunction

    function automatic cue_cmd_t write_cmd(bit [SLOT_W-1:0] slot, bit [TIME_W-1:0] start_ms,
                                           bit [LINE_W-1:0] line);
        cue_cmd_t c;
        c.command  = cti_pkg::CMD_WRITE;
        c.slot     = slot;
        c.start_ms = start_ms;
        c.line     = line;
        c.query_ms = TIME_W'($urandom);
        c.typed    = 1'b0;
        c.want     = NO_CUE;
        return c;
    endfunction

    function automatic cue_cmd_t query_cmd(bit [TIME_W-1:0] t);
        cue_cmd_t c;
        c.command  = cti_pkg::CMD_QUERY;
        c.slot     = SLOT_W'($urandom);
        c.start_ms = TIME_W'($urandom);
        c.line     = LINE_W'($urandom);
        c.query_ms = t;
        c.typed    = 1'b0;
        c.want     = NO_CUE;
        return c;
    endfunction

    function automatic dir_row_t item_row(cue_cmd_t c);
        dir_row_t row;
        row.kind      = ROW_ITEM;
        row.reg_sel   = cti_pkg::REG_ENTRY_COUNT;
        row.reg_value = '0;
        row.cmd       = c;
        return row;
    endfunction

    function automatic dir_row_t want_row(bit [TIME_W-1:0] t, lookup_t want);
        dir_row_t row;
        row = item_row(query_cmd(t));
        row.cmd.typed = 1'b1;
        row.cmd.want  = want;
        return row;
    endfunction

    function automatic dir_row_t reg_row(logic sel, bit [31:0] value);
        dir_row_t row;
        row = item_row(query_cmd('0));
        row.kind      = ROW_REG;
        row.reg_sel   = sel;
        row.reg_value = value;
        return row;
    endfunction

    function automatic void queue_write(bit [SLOT_W-1:0] slot, bit [TIME_W-1:0] start_ms,
                                        bit [LINE_W-1:0] line);
        pending_cmds.push_back(write_cmd(slot, start_ms, line));
        plan_start[slot] = start_ms;
    endfunction

    function automatic bit [31:0] next_gap(bit high_range);
        bit [31:0] g;
        case ($urandom_range(0, 9))
            0:       g = 0;
            1:       g = 1;
            2, 3, 4, 5: g = $urandom_range(1, 200);
            6, 7, 8: g = $urandom_range(200, 70000);
            default: g = $urandom_range(70000, 1 << 22);
        endcase
        if (high_range && g > 60000)
            g = 60000;
        return g;
    endfunction

    // Loads slots 0..slots-1 and picks a song end that suits the layout.
    function automatic void fill_table(int slots, layout_t layout);
        bit [31:0] at;
        bit [31:0] last;
        if (layout == LAYOUT_HIGH)
            at = 32'h7F00_0000 + $urandom_range(0, 16'hFFFF);
        else
            at = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5000);
        for (int i = 0; i < slots; i++)
        begin
            if (layout == LAYOUT_SHUFFLED)
                at = $urandom_range(0, 20000);
            else if (i > 0)
                at = at + next_gap(layout == LAYOUT_HIGH);
            if (at > 32'h7FFF_FFFF)
                at = 32'h7FFF_FFFF;
            queue_write(8'(i), at[TIME_W-1:0], LINE_W'($urandom));
        end
        last = (slots > 0) ? 32'(plan_start[slots - 1]) : $urandom_range(0, 100000);
        case ($urandom_range(0, 5))
            0: plan_song_end = 31'h7FFF_FFFF;
            1: plan_song_end = last[TIME_W-1:0];
            2: plan_song_end = (last > 50) ? TIME_W'(last - $urandom_range(1, 50)) : '0;
            default:
            begin
                at = last + next_gap(1'b0) + 1;
                if (at > 32'h7FFF_FFFF)
                    at = 32'h7FFF_FFFF;
                plan_song_end = at[TIME_W-1:0];
            end
        endcase
    endfunction

    // Query times lean on interval edges, where off-by-one faults live.
    function automatic bit [TIME_W-1:0] pick_query_time(int slots);
        int              i;
        bit [TIME_W-1:0] s;
        bit [TIME_W-1:0] e;
        if (slots == 0 || $urandom_range(0, 9) == 0)
            return TIME_W'($urandom);
        i = $urandom_range(0, slots - 1);
        s = plan_start[i];
        e = (i + 1 < slots) ? plan_start[i + 1] : plan_song_end;
        case ($urandom_range(0, 7))
            0:       return s;
            1:       return s - 1;
            2:       return e - 1;
            3:       return e;
            default: return (e > s) ? s + TIME_W'($urandom_range(0, e - s - 1))
                                    : s + TIME_W'($urandom_range(0, 3));
        endcase
    endfunction

    task automatic report_field(string name, bit [31:0] want, logic [31:0] got);
        err_count++;
        $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
    endtask

    task automatic push_items();
        cue_cmd_t c;
        int       burst_left;
        int       gap;
        burst_left = $urandom_range(1, 12);
        while (pending_cmds.size() > 0)
        begin
            c = pending_cmds.pop_front();
            @(negedge clk);
            req_ch.valid       <= 1'b1;
            req_ch.command     <= c.command;
            req_ch.entry_index <= c.slot;
            req_ch.cue_start   <= c.start_ms;
            req_ch.line_id     <= c.line;
            req_ch.query_time  <= c.query_ms;
            do @(posedge clk); while (req_ch.ready !== 1'b1);
            commit_cmd(c);
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 12);
                gap = tx_gaps ? $urandom_range(0, 10) : 0;
                if (gap > 0)
                begin
                    @(negedge clk);
                    req_ch.valid <= 1'b0;
                    repeat (gap - 1) @(negedge clk);
                end
            end
        end
        @(negedge clk);
        req_ch.valid <= 1'b0;
    endtask

    // Writes happen only once nothing is in flight inside the block.
    task automatic wait_drained();
        while (lookups_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_register(logic sel, bit [31:0] value);
        bit [31:0] want;
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (sel == cti_pkg::REG_ENTRY_COUNT)
        begin
            live_count = value[COUNT_W-1:0];
            want       = 32'(value[COUNT_W-1:0]);
        end
        else
        begin
            live_song_end = value[TIME_W-1:0];
            want          = 32'(value[TIME_W-1:0]);
        end
        // Read the register straight back.
        @(negedge clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (pready !== 1'b1);
        if (prdata !== want)
            report_field("register readback", want, prdata);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    always @(posedge clk)
    begin : check_results
        lookup_t want;
        if (rst_n === 1'b1 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            if (lookups_due.size() == 0)
            begin
                err_count++;
                $display("%0t ns: unexpected result, expected none, got %0h %0h %0h %0h",
                         $time, rsp_ch.found, rsp_ch.hit_index, rsp_ch.hit_line_id,
                         rsp_ch.progress);
            end
            else
            begin
                want = lookups_due.pop_front();
                if (rsp_ch.found !== want.found)
                    report_field("found", want.found, rsp_ch.found);
                if (rsp_ch.hit_index !== want.hit_index)
                    report_field("hit_index", want.hit_index, rsp_ch.hit_index);
                if (rsp_ch.hit_line_id !== want.hit_line_id)
                    report_field("hit_line_id", want.hit_line_id, rsp_ch.hit_line_id);
                if (rsp_ch.progress !== want.progress)
                    report_field("progress", want.progress, rsp_ch.progress);
            end
        end
    end

    initial
    begin : result_stall
        int hold_taken = 0;
        int hold_left  = 0;
        int run_left   = 0;
        bit run_ready  = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_taken != hold_asked)
            begin
                hold_taken = hold_asked;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
            begin
                case (rx_mode)
                    RX_OPEN:   rsp_ch.ready <= 1'b1;
                    RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 9) >= 3);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_ready = !run_ready;
                            run_left  = run_ready ? $urandom_range(1, 8) : $urandom_range(1, 20);
                        end
                        run_left--;
                        rsp_ch.ready <= run_ready;
                    end
                endcase
            end
        end
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("status: fail");
        $finish;
    end

    initial
    begin : run
        int      count;
        int      slots;
        layout_t layout;
        bit [SLOT_W-1:0] slot;
        bit [TIME_W-1:0] start_ms;

        rst_n              = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        req_ch.valid       = 1'b0;
        req_ch.command     = cti_pkg::CMD_WRITE;
        req_ch.entry_index = '0;
        req_ch.cue_start   = '0;
        req_ch.line_id     = '0;
        req_ch.query_time  = '0;
        rsp_ch.ready       = 1'b0;
        live_count         = '0;
        live_song_end      = '0;

        // After reset the table is empty, so nothing can be found.
        directed_rows.push_back(want_row(31'd0, NO_CUE));
        directed_rows.push_back(want_row(31'h7FFF_FFFF, NO_CUE));
        // Slot 1 shares its start with slot 2, so its interval is empty.
        directed_rows.push_back(item_row(write_cmd(8'd0, 31'd1000, 16'hFFFF)));
        directed_rows.push_back(item_row(write_cmd(8'd1, 31'd2000, 16'h0000)));
        directed_rows.push_back(item_row(write_cmd(8'd2, 31'd2000, 16'h1234)));
        directed_rows.push_back(item_row(write_cmd(8'd3, 31'h7FFF_FFF0, 16'hABCD)));
        directed_rows.push_back(item_row(write_cmd(8'd255, 31'h7FFF_FFFF, 16'hFFFF)));
        directed_rows.push_back(reg_row(cti_pkg::REG_ENTRY_COUNT, 32'd4));
        directed_rows.push_back(reg_row(cti_pkg::REG_SONG_END, 32'h7FFF_FFFF));
        directed_rows.push_back(want_row(31'd999, NO_CUE));
        directed_rows.push_back(want_row(31'd1000, '{1'b1, 8'd0, 16'hFFFF, 16'd0}));
        directed_rows.push_back(want_row(31'd1500, '{1'b1, 8'd0, 16'hFFFF, 16'd32768}));
        directed_rows.push_back(want_row(31'd1999, '{1'b1, 8'd0, 16'hFFFF, 16'd65470}));
        directed_rows.push_back(want_row(31'd2000, '{1'b1, 8'd2, 16'h1234, 16'd0}));
        directed_rows.push_back(item_row(query_cmd(31'h7FFF_FFEF)));
        directed_rows.push_back(want_row(31'h7FFF_FFF0, '{1'b1, 8'd3, 16'hABCD, 16'd0}));
        directed_rows.push_back(item_row(query_cmd(31'h7FFF_FFFE)));
        directed_rows.push_back(want_row(31'h7FFF_FFFF, NO_CUE));
        // The song end now equals the last start, so the last cue never matches.
        directed_rows.push_back(reg_row(cti_pkg::REG_SONG_END, 32'hFFFF_FFF0));
        directed_rows.push_back(want_row(31'h7FFF_FFF5, NO_CUE));
        directed_rows.push_back(item_row(query_cmd(31'h4000_0000)));
        // Out of order: slot 1 now starts before slot 0.
        directed_rows.push_back(item_row(write_cmd(8'd1, 31'd500, 16'h0007)));
        directed_rows.push_back(want_row(31'd700, NO_CUE));
        directed_rows.push_back(item_row(query_cmd(31'd1200)));
        directed_rows.push_back(reg_row(cti_pkg::REG_ENTRY_COUNT, 32'd1));
        directed_rows.push_back(item_row(query_cmd(31'd5000)));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[k])
        begin
            if (directed_rows[k].kind == ROW_REG)
            begin
                push_items();
                wait_drained();
                set_register(directed_rows[k].reg_sel, directed_rows[k].reg_value);
            end
            else
                pending_cmds.push_back(directed_rows[k].cmd);
        end
        push_items();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            case (p)
                0:       count = 1;
                1:       count = 2;
                2:       count = 0;
                5:       count = CUE_SLOTS;
                10:      count = 9'h1FF;
                default: count = $urandom_range(3, 24);
            endcase
            slots = (count > CUE_SLOTS) ? CUE_SLOTS : count;
            if (p % 4 == 3)
                layout = LAYOUT_SHUFFLED;
            else if (p % 5 == 4)
                layout = LAYOUT_HIGH;
            else
                layout = LAYOUT_ASCENDING;
            fill_table(slots, layout);

            wait_drained();
            rx_mode = rx_mode_t'(p % 3);
            tx_gaps = (p % 4 != 1);
            set_register(cti_pkg::REG_ENTRY_COUNT,
                         {$urandom_range(0, 1) ? 23'($urandom) : 23'd0, 9'(count)});
            set_register(cti_pkg::REG_SONG_END, {1'($urandom), plan_song_end});

            for (int k = 0; k < PHASE_CMDS; k++)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    if (slots > 0 && $urandom_range(0, 1) == 1)
                    begin
                        slot     = SLOT_W'($urandom_range(0, slots - 1));
                        start_ms = ($urandom_range(0, 4) != 0) ? plan_start[slot]
                                                               : TIME_W'($urandom);
                    end
                    else
                    begin
                        slot     = SLOT_W'($urandom);
                        start_ms = TIME_W'($urandom);
                    end
                    queue_write(slot, start_ms, LINE_W'($urandom));
                end
                else
                    pending_cmds.push_back(query_cmd(pick_query_time(slots)));
            end

            // Hold results back long enough for the block to stall its input.
            if (p == 1)
                hold_asked++;
            push_items();
        end

        wait_drained();
        if (err_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
